// ===== hdl/slcd_pkg.sv =====
// slcd_pkg: shared types, phase codes and constants for the serial lcd write controller
// no dependencies
package slcd_pkg;

    // request codes on the cmd field
    localparam logic [1:0] CMD_NONE       = 2'd0;
    localparam logic [1:0] CMD_WRITE_CMD  = 2'd1;
    localparam logic [1:0] CMD_WRITE_DATA = 2'd2;
    localparam logic [1:0] CMD_RESERVED   = 2'd3;

    // sequencer phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_POLL_TX = 2'd1;
    localparam logic [1:0] PH_POLL_RX = 2'd2;
    localparam logic [1:0] PH_FRAME   = 2'd3;

    localparam logic [7:0] POLL_CODE = 8'hfc;
    localparam logic [7:0] SYNC_CMD  = 8'hf8;
    localparam logic [7:0] SYNC_DATA = 8'hfa;

    // last bit position of each shifting phase
    localparam logic [4:0] LAST_POLL_TX = 5'd7;
    localparam logic [4:0] LAST_POLL_RX = 5'd15;
    localparam logic [4:0] LAST_FRAME   = 5'd23;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic       sid_in;
    } t_slcd_in;

    typedef struct packed {
        logic       chip_select;
        logic       sid_out;
        logic       sid_drive;
        logic       clock_pulse;
        logic       ready_res;
        logic       write_done;
        logic [7:0] status_byte;
    } t_slcd_res;

    typedef struct packed {
        logic [1:0] phase;
        logic [4:0] bit_index;
    } t_slcd_stat;

endpackage

// ===== hdl/slcd_if.sv =====
// slcd_in_if / slcd_out_if: valid/ready channels carrying a slot word and a result word
// no dependencies
interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic       sid_in;

    modport source (output valid, cmd, value, sid_in, input ready);
    modport sink   (input valid, cmd, value, sid_in, output ready);
endinterface

interface slcd_out_if;
    logic       valid;
    logic       ready;
    logic       chip_select;
    logic       sid_out;
    logic       sid_drive;
    logic       clock_pulse;
    logic       ready_res;
    logic       write_done;
    logic [7:0] status_byte;

    modport source (output valid, chip_select, sid_out, sid_drive, clock_pulse, ready_res,
                    write_done, status_byte, input ready);
    modport sink   (input valid, chip_select, sid_out, sid_drive, clock_pulse, ready_res,
                    write_done, status_byte, output ready);
endinterface

// ===== hdl/slcd_step.sv =====
// slcd_step: write sequencer state and the per-slot step logic (poll, status, frame)
// depends on slcd_pkg
module slcd_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  slcd_pkg::t_slcd_in  i_slot,
    output slcd_pkg::t_slcd_res o_res,
    output slcd_pkg::t_slcd_stat o_stat
);

    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_bit_index, n_bit_index;
    logic [23:0] r_tx_shift, n_tx_shift;
    logic [15:0] r_rx_shift, n_rx_shift;
    logic        r_pending_is_data, n_pending_is_data;
    logic [7:0]  r_pending_byte, n_pending_byte;
    logic [7:0]  r_last_status, n_last_status;
    logic [7:0]  sync_byte;

    assign sync_byte = r_pending_is_data ? slcd_pkg::SYNC_DATA : slcd_pkg::SYNC_CMD;

    always_comb begin
        n_phase           = r_phase;
        n_bit_index       = r_bit_index;
        n_tx_shift        = r_tx_shift;
        n_rx_shift        = r_rx_shift;
        n_pending_is_data = r_pending_is_data;
        n_pending_byte    = r_pending_byte;
        n_last_status     = r_last_status;
        o_res             = '0;

        case (r_phase)
            slcd_pkg::PH_IDLE: begin
                o_res.ready_res = 1'b1;
                if (i_slot.cmd == slcd_pkg::CMD_WRITE_CMD
                        || i_slot.cmd == slcd_pkg::CMD_WRITE_DATA) begin
                    n_pending_is_data = (i_slot.cmd == slcd_pkg::CMD_WRITE_DATA);
                    n_pending_byte    = i_slot.value;
                    n_tx_shift        = {slcd_pkg::POLL_CODE, 16'h0000};
                    n_bit_index       = '0;
                    n_phase           = slcd_pkg::PH_POLL_TX;
                    o_res.chip_select = 1'b1;
                end
            end
            slcd_pkg::PH_POLL_TX: begin
                o_res.chip_select = 1'b1;
                o_res.sid_drive   = 1'b1;
                o_res.clock_pulse = 1'b1;
                o_res.sid_out     = r_tx_shift[23];
                n_tx_shift        = {r_tx_shift[22:0], 1'b0};
                if (r_bit_index >= slcd_pkg::LAST_POLL_TX) begin
                    n_bit_index = '0;
                    n_rx_shift  = '0;
                    n_phase     = slcd_pkg::PH_POLL_RX;
                end else begin
                    n_bit_index = r_bit_index + 5'd1;
                end
            end
            slcd_pkg::PH_POLL_RX: begin
                o_res.chip_select = 1'b1;
                o_res.clock_pulse = 1'b1;
                n_rx_shift        = {r_rx_shift[14:0], i_slot.sid_in};
                if (r_bit_index >= slcd_pkg::LAST_POLL_RX) begin
                    // high nibble of the first byte, low nibble of the second
                    n_last_status = {n_rx_shift[15:12], n_rx_shift[3:0]};
                    n_bit_index   = '0;
                    if (n_last_status[7]) begin
                        n_tx_shift = {slcd_pkg::POLL_CODE, 16'h0000};
                        n_phase    = slcd_pkg::PH_POLL_TX;
                    end else begin
                        n_tx_shift = {sync_byte, r_pending_byte[7:4], 4'h0,
                                      r_pending_byte[3:0], 4'h0};
                        n_phase    = slcd_pkg::PH_FRAME;
                    end
                end else begin
                    n_bit_index = r_bit_index + 5'd1;
                end
            end
            default: begin
                o_res.chip_select = 1'b1;
                o_res.sid_drive   = 1'b1;
                o_res.clock_pulse = 1'b1;
                o_res.sid_out     = r_tx_shift[23];
                n_tx_shift        = {r_tx_shift[22:0], 1'b0};
                if (r_bit_index >= slcd_pkg::LAST_FRAME) begin
                    o_res.write_done = 1'b1;
                    n_bit_index      = '0;
                    n_phase          = slcd_pkg::PH_IDLE;
                end else begin
                    n_bit_index = r_bit_index + 5'd1;
                end
            end
        endcase

        o_res.status_byte = n_last_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= slcd_pkg::PH_IDLE;
            r_bit_index   <= '0;
            r_last_status <= '0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_last_status <= n_last_status;
        end
    end

    // loaded before any read, so no reset
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tx_shift        <= n_tx_shift;
            r_rx_shift        <= n_rx_shift;
            r_pending_is_data <= n_pending_is_data;
            r_pending_byte    <= n_pending_byte;
        end
    end

    assign o_stat.phase     = r_phase;
    assign o_stat.bit_index = r_bit_index;

endmodule

// ===== hdl/serial_lcd_write_controller.sv =====
// serial_lcd_write_controller: slot word register, step sequencer and result register
// depends on slcd_pkg, slcd_if and slcd_step
//
//   channel  dir  payload                                                  word
//   i_in     in   cmd, value, sid_in                                       one bit slot
//   o_out    out  chip_select, sid_out, sid_drive, clock_pulse, ready_res, one per slot
//                 write_done, status_byte
//
// one slot word per cycle unless o_out stalls; each word is held in r_in, its result in r_out
// the rate is set by the single registered pass through the sequencer step
// a write takes 1 + 24*n + 24 slots, n being the number of polls, the last of them not busy
// i_rst_n is synchronous; it empties both registers and returns the sequencer to idle
// a stalled result holds in the output register while a further word waits in the input register
module serial_lcd_write_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcd_in_if.sink     i_in,
    slcd_out_if.source  o_out
);

    logic                  r_in_valid;
    slcd_pkg::t_slcd_in    r_in;
    logic                  r_out_valid;
    slcd_pkg::t_slcd_res   r_out;
    logic                  adv;
    slcd_pkg::t_slcd_res   step_res;
    slcd_pkg::t_slcd_stat  step_stat;

    // step fires when the held word can move into the result register
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.cmd    <= i_in.cmd;
            r_in.value  <= i_in.value;
            r_in.sid_in <= i_in.sid_in;
        end
    end

    slcd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_slot  (r_in),
        .o_res   (step_res),
        .o_stat  (step_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.chip_select = r_out.chip_select;
    assign o_out.sid_out     = r_out.sid_out;
    assign o_out.sid_drive   = r_out.sid_drive;
    assign o_out.clock_pulse = r_out.clock_pulse;
    assign o_out.ready_res   = r_out.ready_res;
    assign o_out.write_done  = r_out.write_done;
    assign o_out.status_byte = r_out.status_byte;

    a_idle_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_stat.phase == slcd_pkg::PH_IDLE |-> step_stat.bit_index == 5'd0)
        else $error("bit index not cleared in idle");

    a_poll_tx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_stat.phase == slcd_pkg::PH_POLL_TX |-> step_stat.bit_index <= slcd_pkg::LAST_POLL_TX)
        else $error("poll send overran");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && step_stat.phase == slcd_pkg::PH_FRAME
            && step_stat.bit_index == slcd_pkg::LAST_FRAME
        |=> step_stat.phase == slcd_pkg::PH_IDLE && r_out_valid && r_out.write_done)
        else $error("frame end did not return to idle");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.write_done
        |-> r_out.chip_select && r_out.clock_pulse && r_out.sid_drive && !r_out.ready_res)
        else $error("malformed final frame slot");

endmodule

// ===== tb/tb_serial_lcd_write_controller.sv =====
// tb_serial_lcd_write_controller: self-checking bench for the serial lcd write controller
// drives bit slot words, predicts every result word and compares them field by field
// depends on slcd_pkg, slcd_if and serial_lcd_write_controller
module tb_serial_lcd_write_controller;

    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_SLOTS = 580;

    // tracks the sequencer from accepted slot words and holds the result words still due
    class slcd_scoreboard;
        logic [1:0]  ph;
        logic [4:0]  pos;
        logic [23:0] tx_bits;
        logic [15:0] rx_bits;
        logic        pend_data;
        logic [7:0]  pend_val;
        logic [7:0]  status;
        slcd_pkg::t_slcd_res due_q[$];
        int          errors;
        int          slots;
        int          checked;
        int          writes;
        int          data_writes;
        int          repolls;
        int          ignored;

        function new();
            ph = slcd_pkg::PH_IDLE;
            pos = '0;
            tx_bits = '0;
            rx_bits = '0;
            pend_data = 1'b0;
            pend_val = '0;
            status = '0;
            errors = 0;
            slots = 0;
            checked = 0;
            writes = 0;
            data_writes = 0;
            repolls = 0;
            ignored = 0;
        endfunction

        function bit is_idle();
            return ph == slcd_pkg::PH_IDLE;
        endfunction

        function int waiting();
            return due_q.size();
        endfunction

        function void note_slot(slcd_pkg::t_slcd_in w);
            slcd_pkg::t_slcd_res r;
            logic                req;
            r = '0;
            req = (w.cmd == slcd_pkg::CMD_WRITE_CMD) || (w.cmd == slcd_pkg::CMD_WRITE_DATA);
            slots++;
            if (ph != slcd_pkg::PH_IDLE && req) ignored++;
            case (ph)
                slcd_pkg::PH_IDLE: begin
                    r.ready_res = 1'b1;
                    if (req) begin
                        pend_data = (w.cmd == slcd_pkg::CMD_WRITE_DATA);
                        pend_val = w.value;
                        tx_bits = {slcd_pkg::POLL_CODE, 16'h0000};
                        pos = '0;
                        ph = slcd_pkg::PH_POLL_TX;
                        r.chip_select = 1'b1;
                        writes++;
                        if (pend_data) data_writes++;
                    end
                end
                slcd_pkg::PH_POLL_TX: begin
                    r.chip_select = 1'b1;
                    r.sid_drive = 1'b1;
                    r.clock_pulse = 1'b1;
                    r.sid_out = tx_bits[23];
                    tx_bits = {tx_bits[22:0], 1'b0};
                    if (pos >= slcd_pkg::LAST_POLL_TX) begin
                        pos = '0;
                        rx_bits = '0;
                        ph = slcd_pkg::PH_POLL_RX;
                    end else begin
                        pos = pos + 5'd1;
                    end
                end
                slcd_pkg::PH_POLL_RX: begin
                    r.chip_select = 1'b1;
                    r.clock_pulse = 1'b1;
                    rx_bits = {rx_bits[14:0], w.sid_in};
                    if (pos >= slcd_pkg::LAST_POLL_RX) begin
                        // status takes the high nibble of the first byte, low of the second
                        status = {rx_bits[15:12], rx_bits[3:0]};
                        pos = '0;
                        if (status[7]) begin
                            tx_bits = {slcd_pkg::POLL_CODE, 16'h0000};
                            ph = slcd_pkg::PH_POLL_TX;
                            repolls++;
                        end else begin
                            tx_bits = {pend_data ? slcd_pkg::SYNC_DATA : slcd_pkg::SYNC_CMD,
                                       pend_val[7:4], 4'h0, pend_val[3:0], 4'h0};
                            ph = slcd_pkg::PH_FRAME;
                        end
                    end else begin
                        pos = pos + 5'd1;
                    end
                end
                default: begin
                    r.chip_select = 1'b1;
                    r.sid_drive = 1'b1;
                    r.clock_pulse = 1'b1;
                    r.sid_out = tx_bits[23];
                    tx_bits = {tx_bits[22:0], 1'b0};
                    if (pos >= slcd_pkg::LAST_FRAME) begin
                        r.write_done = 1'b1;
                        pos = '0;
                        ph = slcd_pkg::PH_IDLE;
                    end else begin
                        pos = pos + 5'd1;
                    end
                end
            endcase
            r.status_byte = status;
            due_q.push_back(r);
        endfunction

        function void cmp(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch on result %0d, %s: expected %0h, got %0h",
                             checked, field, want, got);
            end
        endfunction

        function void check_result(slcd_pkg::t_slcd_res got);
            slcd_pkg::t_slcd_res want;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %0h with nothing due", got);
                return;
            end
            want = due_q.pop_front();
            cmp("chip_select", want.chip_select, got.chip_select);
            cmp("sid_out", want.sid_out, got.sid_out);
            cmp("sid_drive", want.sid_drive, got.sid_drive);
            cmp("clock_pulse", want.clock_pulse, got.clock_pulse);
            cmp("ready_res", want.ready_res, got.ready_res);
            cmp("write_done", want.write_done, got.write_done);
            cmp("status_byte", want.status_byte, got.status_byte);
            checked++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    slcd_in_if  in_if();
    slcd_out_if out_if();

    serial_lcd_write_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    slcd_scoreboard sb = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold = 0;
    int slots_driven = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called and returns at a falling edge; the word stays offered until accepted
    task automatic drive_slot(input logic [1:0] c, input logic [7:0] v, input logic s);
        while (tx_idle_on && $urandom_range(0, 99) < 32) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.cmd = c;
        in_if.value = v;
        in_if.sid_in = s;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        slots_driven++;
    endtask

    // stray requests land here too and must be ignored while busy
    task automatic noise_slot();
        drive_slot(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    endtask

    // one full write: request, busy polls answering busy, a final poll with last_word, frame
    task automatic run_write(input logic is_data, input logic [7:0] wr_val,
                             input int busy_polls, input logic [15:0] last_word);
        logic [15:0] word;
        drive_slot(is_data ? slcd_pkg::CMD_WRITE_DATA : slcd_pkg::CMD_WRITE_CMD, wr_val,
                   1'($urandom_range(0, 1)));
        for (int p = 0; p <= busy_polls; p++) begin
            word = (p == busy_polls) ? last_word : {1'b1, 15'($urandom)};
            repeat (8) noise_slot();
            for (int b = 15; b >= 0; b--)
                drive_slot(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), word[b]);
        end
        repeat (24) noise_slot();
    endtask

    // receiver side: random stalls, or a long hold-off when asked for
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_if.ready = 1'b0;
                rx_hold--;
            end else begin
                out_if.ready = !(rx_idle_on && $urandom_range(0, 99) < 32);
            end
        end
    end

    // result first, then the slot word, so the order within an edge is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_result(slcd_pkg::t_slcd_res'({out_if.chip_select, out_if.sid_out,
                                                       out_if.sid_drive, out_if.clock_pulse,
                                                       out_if.ready_res, out_if.write_done,
                                                       out_if.status_byte}));
            if (in_if.valid && in_if.ready)
                sb.note_slot(slcd_pkg::t_slcd_in'({in_if.cmd, in_if.value, in_if.sid_in}));
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("** serial_lcd_write_controller: FAILED **");
        $finish;
    end

    initial begin
        int  directed_slots;
        int  pick;
        bit  held;
        bit  paused;
        in_if.valid = 1'b0;
        in_if.cmd = slcd_pkg::CMD_NONE;
        in_if.value = '0;
        in_if.sid_in = 1'b0;
        i_rst_n = 1'b0;
        held = 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle slots, including the unused request code
        drive_slot(slcd_pkg::CMD_NONE, 8'hff, 1'b1);
        drive_slot(slcd_pkg::CMD_RESERVED, 8'haa, 1'b0);
        // command 0xff with one busy poll, then status 0x7f
        run_write(1'b0, 8'hff, 1, 16'h7fff);
        // data 0x00 straight after, status all zero
        run_write(1'b1, 8'h00, 0, 16'h0000);
        run_write(1'b1, 8'ha5, 2, 16'h5a3c);
        run_write(1'b0, 8'h5a, 0, 16'h0ff0);
        directed_slots = slots_driven;

        while (slots_driven < directed_slots + RANDOM_SLOTS) begin
            // a stretch where neither side idles
            tx_idle_on = !(slots_driven >= 250 && slots_driven < 450);
            rx_idle_on = tx_idle_on;
            if (!held && slots_driven >= 550) begin
                rx_hold = 300;
                held = 1'b1;
            end
            if (!paused && slots_driven >= 700) begin
                in_if.valid = 1'b0;
                while (sb.waiting() != 0) @(negedge i_clk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                repeat ($urandom_range(0, 3))
                    drive_slot($urandom_range(0, 1) ? slcd_pkg::CMD_NONE
                                                    : slcd_pkg::CMD_RESERVED,
                               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                run_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3),
                          {1'b0, 15'($urandom)});
            end else begin
                // broken sequence: raw slots, then run on until the write in flight ends
                repeat ($urandom_range(5, 40)) noise_slot();
                while (!sb.is_idle()) noise_slot();
            end
        end

        in_if.valid = 1'b0;
        while (sb.waiting() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("covered %0d slot words and %0d result words: %0d writes (%0d data)",
                 sb.slots, sb.checked, sb.writes, sb.data_writes);
        $display("with %0d busy re-polls and %0d requests ignored while busy",
                 sb.repolls, sb.ignored);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("** serial_lcd_write_controller: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results still due", sb.errors, sb.waiting());
            $display("** serial_lcd_write_controller: FAILED **");
        end
        $finish;
    end

endmodule
